// ===== hdl/ldmf_pkg.sv =====
package ldmf_pkg;

	localparam int COEF_W = 48;
	localparam int FX_W = 64;
	localparam int PIX_W = 14;
	localparam int OUT_W = 32;
	localparam int SLOT_W = 4;
	localparam int NUM_SLOTS = 13;
	localparam int LIM_W = 17;
	localparam int DEF_MAX_COLUMNS = 8192;
	localparam int DEF_MAX_ROWS = 8192;
	localparam int IN_DATA_W = SLOT_W + COEF_W + 2 * PIX_W;
	localparam int OUT_DATA_W = 2 * OUT_W;

	localparam logic [SLOT_W-1:0] SL_IN_SCALE_X = 4'd0;
	localparam logic [SLOT_W-1:0] SL_IN_OFF_X = 4'd1;
	localparam logic [SLOT_W-1:0] SL_IN_SCALE_Y = 4'd2;
	localparam logic [SLOT_W-1:0] SL_IN_OFF_Y = 4'd3;
	localparam logic [SLOT_W-1:0] SL_K1 = 4'd4;
	localparam logic [SLOT_W-1:0] SL_K2 = 4'd5;
	localparam logic [SLOT_W-1:0] SL_K3 = 4'd6;
	localparam logic [SLOT_W-1:0] SL_P1 = 4'd7;
	localparam logic [SLOT_W-1:0] SL_P2 = 4'd8;
	localparam logic [SLOT_W-1:0] SL_OUT_SCALE_X = 4'd9;
	localparam logic [SLOT_W-1:0] SL_OUT_OFF_X = 4'd10;
	localparam logic [SLOT_W-1:0] SL_OUT_SCALE_Y = 4'd11;
	localparam logic [SLOT_W-1:0] SL_OUT_OFF_Y = 4'd12;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MAP = 1'b1;

	localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
	localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic ovf;
		logic signed [FX_W-1:0] v;
	} fx_t;

	localparam fx_t FX_UNIT = '{ovf: 1'b0, v: 64'sh0000_0001_0000_0000};

	typedef struct packed {
		logic vld;
		logic map;
		logic [SLOT_W-1:0] idx;
		coef_t val;
	} ctl_t;

	typedef struct packed {
		logic [PIX_W-1:0] row;
		logic [PIX_W-1:0] col;
		coef_t val;
		logic [SLOT_W-1:0] idx;
	} in_data_t;

	typedef struct packed {
		logic sat;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] x;
	} res_t;

	function automatic fx_t sadd(input fx_t a, input fx_t b);
		logic [FX_W:0] s;
		fx_t r;
		s = {a.v[FX_W-1], a.v} + {b.v[FX_W-1], b.v};
		r.ovf = a.ovf | b.ovf;
		r.v = s[FX_W-1:0];
		if (s[FX_W] != s[FX_W-1]) begin
			r.ovf = 1'b1;
			r.v = s[FX_W] ? FX_MIN : FX_MAX;
		end
		return r;
	endfunction

	function automatic fx_t from_coef(input coef_t c);
		fx_t r;
		r.ovf = 1'b0;
		r.v = {{(FX_W-COEF_W){c[COEF_W-1]}}, c};
		return r;
	endfunction

	function automatic logic is_load(input ctl_t c, input logic [SLOT_W-1:0] slot);
		return c.vld && (c.map == OP_LOAD) && (c.idx == slot);
	endfunction

endpackage

// ===== hdl/ldmf_dly.sv =====
module ldmf_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) tap_q[i] <= '0;
		end else if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < N; i++) tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[N-1];

endmodule

// ===== hdl/ldmf_qmul.sv =====
module ldmf_qmul (
	input  logic          clk,
	input  logic          en,
	input  ldmf_pkg::fx_t a,
	input  ldmf_pkg::fx_t b,
	output ldmf_pkg::fx_t p
);
	import ldmf_pkg::*;

	localparam int H = FX_W / 2;
	localparam int P_W = 2 * FX_W;

	logic [FX_W-1:0] ma_s1, mb_s1;
	logic neg_s1, ovf_s1;
	logic [FX_W-1:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic neg_s2, ovf_s2;
	logic [FX_W:0] mid_s3;
	logic [P_W-1:0] cat_s3;
	logic neg_s3, ovf_s3;
	logic [P_W-1:0] mag_s4;
	logic neg_s4, ovf_s4;
	logic [P_W-1:0] w;
	fx_t res, p_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= a.v[FX_W-1] ? FX_W'(-a.v) : a.v;
			mb_s1 <= b.v[FX_W-1] ? FX_W'(-b.v) : b.v;
			neg_s1 <= a.v[FX_W-1] ^ b.v[FX_W-1];
			ovf_s1 <= a.ovf | b.ovf;

			p00_s2 <= ma_s1[H-1:0] * mb_s1[H-1:0];
			p01_s2 <= ma_s1[H-1:0] * mb_s1[FX_W-1:H];
			p10_s2 <= ma_s1[FX_W-1:H] * mb_s1[H-1:0];
			p11_s2 <= ma_s1[FX_W-1:H] * mb_s1[FX_W-1:H];
			neg_s2 <= neg_s1;
			ovf_s2 <= ovf_s1;

			mid_s3 <= {1'b0, p01_s2} + {1'b0, p10_s2};
			cat_s3 <= {p11_s2, p00_s2};
			neg_s3 <= neg_s2;
			ovf_s3 <= ovf_s2;

			mag_s4 <= cat_s3 + {{(H-1){1'b0}}, mid_s3, {H{1'b0}}};
			neg_s4 <= neg_s3;
			ovf_s4 <= ovf_s3;

			p_s5 <= res;
		end
	end

	// round half up at bit 31, keep bits 95:32
	always_comb begin
		w = (neg_s4 ? ~mag_s4 : mag_s4) + {{(P_W-H){1'b0}}, 1'b1, {(H-1){1'b0}}}
			+ {{(P_W-1){1'b0}}, neg_s4};
		res.ovf = ovf_s4;
		res.v = w[FX_W+H-1:H];
		if (w[P_W-1:FX_W+H-1] != {(H+1){w[FX_W+H-1]}}) begin
			res.ovf = 1'b1;
			res.v = w[P_W-1] ? FX_MIN : FX_MAX;
		end
	end

	assign p = p_s5;

endmodule

// ===== hdl/ldmf_out.sv =====
module ldmf_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               vld_in,
	input  ldmf_pkg::fx_t                      ox,
	input  ldmf_pkg::fx_t                      oy,
	output logic                               rdy,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ldmf_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                               m_tuser
);
	import ldmf_pkg::*;

	localparam int Q_W = FX_W - 16;

	typedef struct packed {
		logic sat;
		logic signed [OUT_W-1:0] v;
	} q16_t;

	function automatic q16_t to_q16(input fx_t x);
		logic [FX_W:0] w;
		logic [Q_W-1:0] q;
		q16_t r;
		w = {x.v[FX_W-1], x.v} + (FX_W+1)'(32768);
		q = w[FX_W-1:16];
		r.sat = x.ovf;
		r.v = q[OUT_W-1:0];
		if (w[FX_W] != w[FX_W-1]) begin
			r.sat = 1'b1;
			r.v = OUT_MAX;
		end else if (q[Q_W-1:OUT_W-1] != {(Q_W-OUT_W+1){q[OUT_W-1]}}) begin
			r.sat = 1'b1;
			r.v = q[Q_W-1] ? OUT_MIN : OUT_MAX;
		end
		return r;
	endfunction

	q16_t qx, qy;
	res_t res_new, out_q, skid_q;
	logic out_v_q, skid_v_q, new_v, load_out;

	always_comb begin
		qx = to_q16(ox);
		qy = to_q16(oy);
		res_new.x = qx.v;
		res_new.y = qy.v;
		res_new.sat = qx.sat | qy.sat;
	end

	assign rdy = !skid_v_q;
	assign new_v = vld_in && rdy;
	assign load_out = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= skid_v_q || new_v;
			skid_v_q <= 1'b0;
		end else if (new_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_v_q ? skid_q : res_new;
		end else if (new_v) begin
			skid_q <= res_new;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {out_q.y, out_q.x};
	assign m_tuser = out_q.sat;

endmodule

// ===== hdl/lens_distortion_map_forward.sv =====
// channel   dir  tdata (low bit up)                          tuser
// s_*       in   coef_index, coef_value, pixel_column, row   opcode
// m_*       out  source_x, source_y                          saturated
//
// one item per clock while the pipeline is not held; a map item's result
// reaches the output register through the chain of 64x64 multiplier units
// reset clears all valid bits; coefficients are undefined until loaded
// load items update each coefficient as they pass the stage that uses it
// the pipeline holds only when both output register and skid stage are full
module lens_distortion_map_forward #(
	parameter int MAX_COLUMNS = ldmf_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS = ldmf_pkg::DEF_MAX_ROWS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ldmf_pkg::IN_DATA_W-1:0]     s_tdata,  // coef_index, coef_value, pixel_column, pixel_row
	input  logic                               s_tuser,  // opcode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ldmf_pkg::OUT_DATA_W-1:0]    m_tdata,  // source_x, source_y
	output logic                               m_tuser   // saturated
);
	import ldmf_pkg::*;

	localparam logic [LIM_W-1:0] LIM_C = LIM_W'(MAX_COLUMNS);
	localparam logic [LIM_W-1:0] LIM_R = LIM_W'(MAX_ROWS);
	localparam int CTL_W = $bits(ctl_t);
	localparam int FXB = $bits(fx_t);

	logic en;
	in_data_t din;
	logic [PIX_W-1:0] col_c, row_c, col_s1, row_s1;
	ctl_t ctl_s1, ctl_s2, ctl_s9, ctl_s10, ctl_s14, ctl_s19, ctl_s32, ctl_s37, ctl_s38;
	coef_t coef_q [NUM_SLOTS];
	logic signed [COEF_W+PIX_W:0] px_s2, py_s2;
	fx_t xn_s3, yn_s3, xx_s8, yy_s8, xy_s8;
	fx_t r2_s9, t_s9, x2_s9, y2_s9, ax_s10, ay_s10, t_s10;
	fx_t r4_s14, k1r2_s14, r2_s14, ra_s15, ra_s19;
	fx_t p1t_s15, p2ax_s15, p2t_s15, p1ay_s15;
	fx_t r6_s19, k2r4_s19, rb_s20, rb_s24, k3r6_s24, rad_s25;
	fx_t xn_s25, yn_s25, xnr_s30, ynr_s30, p1t_s30, p2t_s30, p2ax_s31, p1ay_s31;
	fx_t xz1_s31, yz1_s31, xz_s32, yz_s32, mx_s37, my_s37, ox_s38, oy_s38;

	assign s_tready = en;
	assign din = s_tdata;

	always_comb begin
		col_c = din.col;
		if (din.col == '0) col_c = PIX_W'(1);
		else if ({{(LIM_W-PIX_W){1'b0}}, din.col} > LIM_C) col_c = LIM_C[PIX_W-1:0];
		row_c = din.row;
		if (din.row == '0) row_c = PIX_W'(1);
		else if ({{(LIM_W-PIX_W){1'b0}}, din.row} > LIM_R) row_c = LIM_R[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.vld <= s_tvalid;
			ctl_s1.map <= s_tuser;
			ctl_s1.idx <= din.idx;
			ctl_s1.val <= din.val;
		end
	end

	ldmf_dly #(.W(CTL_W), .N(1))  u_c2  (.clk, .arst_n, .en, .d(ctl_s1),  .q(ctl_s2));
	ldmf_dly #(.W(CTL_W), .N(7))  u_c9  (.clk, .arst_n, .en, .d(ctl_s2),  .q(ctl_s9));
	ldmf_dly #(.W(CTL_W), .N(1))  u_c10 (.clk, .arst_n, .en, .d(ctl_s9),  .q(ctl_s10));
	ldmf_dly #(.W(CTL_W), .N(4))  u_c14 (.clk, .arst_n, .en, .d(ctl_s10), .q(ctl_s14));
	ldmf_dly #(.W(CTL_W), .N(5))  u_c19 (.clk, .arst_n, .en, .d(ctl_s14), .q(ctl_s19));
	ldmf_dly #(.W(CTL_W), .N(13)) u_c32 (.clk, .arst_n, .en, .d(ctl_s19), .q(ctl_s32));
	ldmf_dly #(.W(CTL_W), .N(5))  u_c37 (.clk, .arst_n, .en, .d(ctl_s32), .q(ctl_s37));
	ldmf_dly #(.W(CTL_W), .N(1))  u_c38 (.clk, .arst_n, .en, .d(ctl_s37), .q(ctl_s38));

	// each coefficient lives at the stage that consumes it
	always_ff @(posedge clk) begin
		if (en) begin
			if (is_load(ctl_s1, SL_IN_SCALE_X)) coef_q[SL_IN_SCALE_X] <= ctl_s1.val;
			if (is_load(ctl_s1, SL_IN_SCALE_Y)) coef_q[SL_IN_SCALE_Y] <= ctl_s1.val;
			if (is_load(ctl_s2, SL_IN_OFF_X)) coef_q[SL_IN_OFF_X] <= ctl_s2.val;
			if (is_load(ctl_s2, SL_IN_OFF_Y)) coef_q[SL_IN_OFF_Y] <= ctl_s2.val;
			if (is_load(ctl_s9, SL_K1)) coef_q[SL_K1] <= ctl_s9.val;
			if (is_load(ctl_s10, SL_P1)) coef_q[SL_P1] <= ctl_s10.val;
			if (is_load(ctl_s10, SL_P2)) coef_q[SL_P2] <= ctl_s10.val;
			if (is_load(ctl_s14, SL_K2)) coef_q[SL_K2] <= ctl_s14.val;
			if (is_load(ctl_s19, SL_K3)) coef_q[SL_K3] <= ctl_s19.val;
			if (is_load(ctl_s32, SL_OUT_SCALE_X)) coef_q[SL_OUT_SCALE_X] <= ctl_s32.val;
			if (is_load(ctl_s32, SL_OUT_SCALE_Y)) coef_q[SL_OUT_SCALE_Y] <= ctl_s32.val;
			if (is_load(ctl_s37, SL_OUT_OFF_X)) coef_q[SL_OUT_OFF_X] <= ctl_s37.val;
			if (is_load(ctl_s37, SL_OUT_OFF_Y)) coef_q[SL_OUT_OFF_Y] <= ctl_s37.val;
		end
	end

	// input affine map
	always_ff @(posedge clk) begin
		if (en) begin
			col_s1 <= col_c;
			row_s1 <= row_c;
			px_s2 <= coef_q[SL_IN_SCALE_X] * $signed({1'b0, col_s1});
			py_s2 <= coef_q[SL_IN_SCALE_Y] * $signed({1'b0, row_s1});
			xn_s3.ovf <= 1'b0;
			yn_s3.ovf <= 1'b0;
			xn_s3.v <= FX_W'(px_s2) + FX_W'(coef_q[SL_IN_OFF_X]);
			yn_s3.v <= FX_W'(py_s2) + FX_W'(coef_q[SL_IN_OFF_Y]);
		end
	end

	ldmf_qmul u_xx (.clk, .en, .a(xn_s3), .b(xn_s3), .p(xx_s8));
	ldmf_qmul u_yy (.clk, .en, .a(yn_s3), .b(yn_s3), .p(yy_s8));
	ldmf_qmul u_xy (.clk, .en, .a(xn_s3), .b(yn_s3), .p(xy_s8));

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s9 <= sadd(xx_s8, yy_s8);
			t_s9 <= sadd(xy_s8, xy_s8);
			x2_s9 <= sadd(xx_s8, xx_s8);
			y2_s9 <= sadd(yy_s8, yy_s8);
			ax_s10 <= sadd(r2_s9, x2_s9);
			ay_s10 <= sadd(r2_s9, y2_s9);
			t_s10 <= t_s9;
		end
	end

	ldmf_qmul u_r4   (.clk, .en, .a(r2_s9), .b(r2_s9), .p(r4_s14));
	ldmf_qmul u_k1   (.clk, .en, .a(from_coef(coef_q[SL_K1])), .b(r2_s9), .p(k1r2_s14));
	ldmf_qmul u_p1t  (.clk, .en, .a(from_coef(coef_q[SL_P1])), .b(t_s10), .p(p1t_s15));
	ldmf_qmul u_p2ax (.clk, .en, .a(from_coef(coef_q[SL_P2])), .b(ax_s10), .p(p2ax_s15));
	ldmf_qmul u_p2t  (.clk, .en, .a(from_coef(coef_q[SL_P2])), .b(t_s10), .p(p2t_s15));
	ldmf_qmul u_p1ay (.clk, .en, .a(from_coef(coef_q[SL_P1])), .b(ay_s10), .p(p1ay_s15));

	ldmf_dly #(.W(FXB), .N(5)) u_r2d (.clk, .arst_n, .en, .d(r2_s9), .q(r2_s14));

	always_ff @(posedge clk) begin
		if (en) ra_s15 <= sadd(FX_UNIT, k1r2_s14);
	end

	ldmf_qmul u_r6 (.clk, .en, .a(r4_s14), .b(r2_s14), .p(r6_s19));
	ldmf_qmul u_k2 (.clk, .en, .a(from_coef(coef_q[SL_K2])), .b(r4_s14), .p(k2r4_s19));
	ldmf_dly #(.W(FXB), .N(4)) u_rad (.clk, .arst_n, .en, .d(ra_s15), .q(ra_s19));

	always_ff @(posedge clk) begin
		if (en) rb_s20 <= sadd(ra_s19, k2r4_s19);
	end

	ldmf_qmul u_k3 (.clk, .en, .a(from_coef(coef_q[SL_K3])), .b(r6_s19), .p(k3r6_s24));
	ldmf_dly #(.W(FXB), .N(4)) u_rbd (.clk, .arst_n, .en, .d(rb_s20), .q(rb_s24));

	always_ff @(posedge clk) begin
		if (en) rad_s25 <= sadd(rb_s24, k3r6_s24);
	end

	ldmf_dly #(.W(FXB), .N(22)) u_xnd (.clk, .arst_n, .en, .d(xn_s3), .q(xn_s25));
	ldmf_dly #(.W(FXB), .N(22)) u_ynd (.clk, .arst_n, .en, .d(yn_s3), .q(yn_s25));

	ldmf_qmul u_xnr (.clk, .en, .a(xn_s25), .b(rad_s25), .p(xnr_s30));
	ldmf_qmul u_ynr (.clk, .en, .a(yn_s25), .b(rad_s25), .p(ynr_s30));

	ldmf_dly #(.W(FXB), .N(15)) u_p1td  (.clk, .arst_n, .en, .d(p1t_s15),  .q(p1t_s30));
	ldmf_dly #(.W(FXB), .N(15)) u_p2td  (.clk, .arst_n, .en, .d(p2t_s15),  .q(p2t_s30));
	ldmf_dly #(.W(FXB), .N(16)) u_p2axd (.clk, .arst_n, .en, .d(p2ax_s15), .q(p2ax_s31));
	ldmf_dly #(.W(FXB), .N(16)) u_p1ayd (.clk, .arst_n, .en, .d(p1ay_s15), .q(p1ay_s31));

	always_ff @(posedge clk) begin
		if (en) begin
			xz1_s31 <= sadd(xnr_s30, p1t_s30);
			yz1_s31 <= sadd(ynr_s30, p2t_s30);
			xz_s32 <= sadd(xz1_s31, p2ax_s31);
			yz_s32 <= sadd(yz1_s31, p1ay_s31);
		end
	end

	// output affine map
	ldmf_qmul u_mx (.clk, .en, .a(from_coef(coef_q[SL_OUT_SCALE_X])), .b(xz_s32), .p(mx_s37));
	ldmf_qmul u_my (.clk, .en, .a(from_coef(coef_q[SL_OUT_SCALE_Y])), .b(yz_s32), .p(my_s37));

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s38 <= sadd(mx_s37, from_coef(coef_q[SL_OUT_OFF_X]));
			oy_s38 <= sadd(my_s37, from_coef(coef_q[SL_OUT_OFF_Y]));
		end
	end

	ldmf_out u_out (
		.clk,
		.arst_n,
		.vld_in(ctl_s38.vld && (ctl_s38.map == OP_MAP)),
		.ox(ox_s38),
		.oy(oy_s38),
		.rdy(en),
		.m_tvalid,
		.m_tready,
		.m_tdata,
		.m_tuser
	);

	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("pipeline held without a waiting result");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_tready && m_tready) |=> s_tready)
		else $error("skid stage did not drain");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s38.vld && (ctl_s38.map == OP_MAP) && s_tready) |=> m_tvalid)
		else $error("finished item not presented");

endmodule

// ===== dv/lens_distortion_map_forward_test.sv =====
module lens_distortion_map_forward_test;
	import ldmf_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;  // coef_index, coef_value, pixel_column, pixel_row
	logic s_tuser = OP_LOAD;  // opcode
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;  // source_x, source_y
	logic m_tuser;  // saturated

	int send_idle = 0;
	int recv_idle = 0;
	int errors = 0;
	int quiet_cycles = 0;

	coef_t coef_shadow [NUM_SLOTS];
	res_t pending_maps [$];

	lens_distortion_map_forward dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
			input logic signed [63:0] b, inout logic sat);
		logic signed [127:0] p;
		p = a * b;
		p = p + 128'sd2147483648;
		p = p >>> 32;
		if (p[127:63] != {65{p[63]}}) begin
			sat = 1'b1;
			return p[127] ? FX_MIN : FX_MAX;
		end
		return p[63:0];
	endfunction

	function automatic logic signed [63:0] fx_add(input logic signed [63:0] a,
			input logic signed [63:0] b, inout logic sat);
		logic signed [64:0] s;
		s = a + b;
		if (s[64] != s[63]) begin
			sat = 1'b1;
			return s[64] ? FX_MIN : FX_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] to_q16(input logic signed [63:0] v, inout logic sat);
		logic signed [64:0] w;
		logic signed [64:0] q;
		w = v + 65'sd32768;
		if (w > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
			sat = 1'b1;
			return OUT_MAX;
		end
		q = w >>> 16;
		if (q > 65'sd2147483647) begin
			sat = 1'b1;
			return OUT_MAX;
		end
		if (q < -65'sd2147483648) begin
			sat = 1'b1;
			return OUT_MIN;
		end
		return q[31:0];
	endfunction

	function automatic res_t predict_map(input logic [PIX_W-1:0] col_in,
			input logic [PIX_W-1:0] row_in);
		logic signed [63:0] col, row, xn, yn, xx, yy, r2, r4, r6, rad, xy, t, xz, yz, ox, oy;
		logic signed [63:0] c [NUM_SLOTS];
		logic f;
		res_t r;
		f = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) c[i] = coef_shadow[i];
		col = col_in;
		row = row_in;
		if (col < 1) col = 1;
		if (col > DEF_MAX_COLUMNS) col = DEF_MAX_COLUMNS;
		if (row < 1) row = 1;
		if (row > DEF_MAX_ROWS) row = DEF_MAX_ROWS;
		xn = c[SL_IN_SCALE_X] * col + c[SL_IN_OFF_X];
		yn = c[SL_IN_SCALE_Y] * row + c[SL_IN_OFF_Y];
		xx = fx_mul(xn, xn, f);
		yy = fx_mul(yn, yn, f);
		r2 = fx_add(xx, yy, f);
		r4 = fx_mul(r2, r2, f);
		r6 = fx_mul(r4, r2, f);
		rad = fx_add(FX_UNIT.v, fx_mul(c[SL_K1], r2, f), f);
		rad = fx_add(rad, fx_mul(c[SL_K2], r4, f), f);
		rad = fx_add(rad, fx_mul(c[SL_K3], r6, f), f);
		xy = fx_mul(xn, yn, f);
		t = fx_add(xy, xy, f);
		xz = fx_add(fx_mul(xn, rad, f), fx_mul(c[SL_P1], t, f), f);
		xz = fx_add(xz, fx_mul(c[SL_P2], fx_add(r2, fx_add(xx, xx, f), f), f), f);
		yz = fx_add(fx_mul(yn, rad, f), fx_mul(c[SL_P2], t, f), f);
		yz = fx_add(yz, fx_mul(c[SL_P1], fx_add(r2, fx_add(yy, yy, f), f), f), f);
		ox = fx_add(fx_mul(c[SL_OUT_SCALE_X], xz, f), c[SL_OUT_OFF_X], f);
		oy = fx_add(fx_mul(c[SL_OUT_SCALE_Y], yz, f), c[SL_OUT_OFF_Y], f);
		r.x = to_q16(ox, f);
		r.y = to_q16(oy, f);
		r.sat = f;
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task automatic send_item(input logic op, input logic [SLOT_W-1:0] idx, input coef_t val,
			input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {row, col, val, idx};
		s_tuser <= op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (op == OP_LOAD) begin
			if (idx < NUM_SLOTS) coef_shadow[idx] = val;
		end else begin
			pending_maps = {pending_maps, predict_map(col, row)};
		end
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_maps.size() == 0) begin
				report("unexpected item", m_tdata[OUT_W-1:0], 0);
			end else begin
				res_t want;
				want = pending_maps.pop_front();
				if ($signed(m_tdata[OUT_W-1:0]) != want.x)
					report("source_x", $signed(m_tdata[OUT_W-1:0]), want.x);
				if ($signed(m_tdata[2*OUT_W-1:OUT_W]) != want.y)
					report("source_y", $signed(m_tdata[2*OUT_W-1:OUT_W]), want.y);
				if (m_tuser != want.sat) report("saturated", m_tuser, want.sat);
			end
		end
	end

	function automatic coef_t rnd48();
		return coef_t'({$urandom, $urandom});
	endfunction

	function automatic coef_t spread(input int n);
		coef_t v;
		v = rnd48();
		return v >>> (47 - n);
	endfunction

	task automatic map(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
		send_item(OP_MAP, '0, rnd48(), col, row);
	endtask

	task automatic load(input logic [SLOT_W-1:0] idx, input coef_t val);
		send_item(OP_LOAD, idx, val, PIX_W'($urandom), PIX_W'($urandom));
	endtask

	task automatic load_lens_set();
		load(SL_IN_SCALE_X, 48'sd1048576 + spread(16));
		load(SL_IN_OFF_X, -48'sd4294967296 + spread(28));
		load(SL_IN_SCALE_Y, 48'sd1048576 + spread(16));
		load(SL_IN_OFF_Y, -48'sd4294967296 + spread(28));
		load(SL_K1, spread(30));
		load(SL_K2, spread(28));
		load(SL_K3, spread(26));
		load(SL_P1, spread(24));
		load(SL_P2, spread(24));
		load(SL_OUT_SCALE_X, 48'sh1000_0000_0000 + spread(40));
		load(SL_OUT_OFF_X, 48'sh1000_0000_0000 + spread(40));
		load(SL_OUT_SCALE_Y, 48'sh1000_0000_0000 + spread(40));
		load(SL_OUT_OFF_Y, 48'sh1000_0000_0000 + spread(40));
	endtask

	task automatic test_corners();
		load_lens_set();
		map(PIX_W'(1), PIX_W'(1));
		map(PIX_W'(DEF_MAX_COLUMNS), PIX_W'(DEF_MAX_ROWS));
		map(PIX_W'(0), PIX_W'(0));
		map('1, '1);
		map(PIX_W'(1), PIX_W'(DEF_MAX_ROWS));
		map(PIX_W'(DEF_MAX_COLUMNS + 1), PIX_W'(1));
	endtask

	task automatic test_unused_slots();
		load(4'd13, rnd48());
		load(4'd14, 48'sh7FFF_FFFF_FFFF);
		load(4'd15, 48'sh8000_0000_0000);
		map(PIX_W'(100), PIX_W'(200));
	endtask

	task automatic test_overflow();
		load(SL_K1, 48'sh7FFF_FFFF_FFFF);
		map(PIX_W'(DEF_MAX_COLUMNS), PIX_W'(DEF_MAX_ROWS));
		load(SL_OUT_SCALE_X, 48'sh8000_0000_0000);
		load(SL_OUT_OFF_Y, 48'sh7FFF_FFFF_FFFF);
		map(PIX_W'(1), PIX_W'(1));
		map(PIX_W'(4096), PIX_W'(4096));
	endtask

	task automatic test_random_stream(input int sets);
		repeat (sets) begin
			load_lens_set();
			if ($urandom_range(3) == 0) load(4'($urandom_range(15)), rnd48());
			repeat ($urandom_range(30, 50)) begin
				if ($urandom_range(19) == 0) load(4'($urandom_range(15)), rnd48());
				if ($urandom_range(15) == 0) map(PIX_W'($urandom), PIX_W'($urandom));
				else map(PIX_W'($urandom_range(1, DEF_MAX_COLUMNS)),
					PIX_W'($urandom_range(1, DEF_MAX_ROWS)));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 6;
		recv_idle = 56;
		test_corners();
		test_unused_slots();
		test_overflow();
		test_random_stream(10);
		send_idle = 56;
		recv_idle = 6;
		test_random_stream(10);
		send_idle = 0;
		recv_idle = 0;
		test_random_stream(10);
		s_tvalid <= 1'b0;
		while (pending_maps.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== lens_distortion_map_forward.f =====
hdl/ldmf_pkg.sv
hdl/ldmf_dly.sv
hdl/ldmf_qmul.sv
hdl/ldmf_out.sv
hdl/lens_distortion_map_forward.sv
dv/lens_distortion_map_forward_test.sv
